>>> design/fcbapwm_pkg.sv
// Shared types and constants for the four-channel bit-angle PWM.
package fcbapwm_pkg;

    localparam int LEVEL_W          = 12;
    localparam int NUM_CH           = 4;
    localparam int MAX_BITS_DEFAULT = 12;

    localparam int CFG_W      = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_BITS_IN_USE  = 3'd0;
    localparam logic [CFG_W-1:0]      BITS_IN_USE_RESET = 4'd12;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_WHITE = 3;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef level_t [NUM_CH-1:0] level_set_t;

endpackage

>>> design/fcbapwm_if.sv
// Valid/ready channel interfaces for level items and pin results.
interface fcbapwm_in_if;
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    fcbapwm_pkg::level_t    red_level;
    fcbapwm_pkg::level_t    green_level;
    fcbapwm_pkg::level_t    blue_level;
    fcbapwm_pkg::level_t    white_level;

    modport source (output valid, opcode, red_level, green_level, blue_level, white_level,
                    input ready);
    modport sink   (input valid, opcode, red_level, green_level, blue_level, white_level,
                    output ready);
endinterface

interface fcbapwm_out_if;
    logic valid;
    logic ready;
    logic red_pin;
    logic green_pin;
    logic blue_pin;
    logic white_pin;
    logic frame_start;

    modport source (output valid, red_pin, green_pin, blue_pin, white_pin, frame_start,
                    input ready);
    modport sink   (input valid, red_pin, green_pin, blue_pin, white_pin, frame_start,
                    output ready);
endinterface

>>> design/four_channel_bit_angle_pwm.sv
// Top level: four-channel bit-angle PWM with APB configuration register.
// An accepted item's result is registered in the output register in the next cycle.
// Throughput: one item per cycle; the single-entry result register refills in the
// cycle it is taken, so the block stalls only while a result waits unread.
// Bit k of each level is held for 2^k ticks; a frame lasts 2^N - 1 ticks, N being bits_in_use clamped to 1..MAX_BITS.
// Reset (rst_n, asynchronous, active low) clears levels, pending flag, bit position,
// tick count and the result valid flag, and sets bits_in_use to 12.
module four_channel_bit_angle_pwm #(
    parameter int MAX_BITS = fcbapwm_pkg::MAX_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    fcbapwm_in_if.sink                         item,
    fcbapwm_out_if.source                      result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fcbapwm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fcbapwm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fcbapwm_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);

    localparam int BPW = $clog2(MAX_BITS);
    localparam int TW  = MAX_BITS - 1;
    localparam int NW  = BPW + 1;
    localparam int CW  = (NW > fcbapwm_pkg::CFG_W) ? NW : fcbapwm_pkg::CFG_W;

    logic [fcbapwm_pkg::CFG_W-1:0] bits_in_use_reg;
    fcbapwm_pkg::level_set_t       active_reg, active_next;
    fcbapwm_pkg::level_set_t       pending_reg, pending_next;
    logic                          pending_valid_reg, pending_valid_next;
    logic [BPW-1:0]                bit_pos_reg, bit_pos_next;
    logic [TW-1:0]                 tick_reg, tick_next;

    logic                          out_valid_reg;
    logic [fcbapwm_pkg::NUM_CH-1:0] pins_reg, pins_next;
    logic                          frame_start_reg, frame_start_next;

    logic                          accept;
    logic [CW-1:0]                 cfg_ext;
    logic [CW-1:0]                 eff_bits;
    logic [CW-1:0]                 pos_inc;
    logic [MAX_BITS-1:0]           tick_inc;
    logic [MAX_BITS-1:0]           hold_len;
    logic                          hold_done;
    logic                          wrap;

    // APB register
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == fcbapwm_pkg::ADDR_BITS_IN_USE)
        begin
            prdata[fcbapwm_pkg::CFG_W-1:0] = bits_in_use_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_use_reg <= fcbapwm_pkg::BITS_IN_USE_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr == fcbapwm_pkg::ADDR_BITS_IN_USE)
        begin
            bits_in_use_reg <= pwdata[fcbapwm_pkg::CFG_W-1:0];
        end
    end

    // Handshake: take a new item whenever the result slot is free or being drained
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    // Clamp bits_in_use to 1..MAX_BITS
    assign cfg_ext = CW'(bits_in_use_reg);

    always_comb
    begin
        if (cfg_ext == '0)
        begin
            eff_bits = CW'(1);
        end
        else if (cfg_ext > CW'(MAX_BITS))
        begin
            eff_bits = CW'(MAX_BITS);
        end
        else
        begin
            eff_bits = cfg_ext;
        end
    end

    assign pos_inc   = CW'(bit_pos_reg) + CW'(1);
    assign tick_inc  = MAX_BITS'(tick_reg) + MAX_BITS'(1);
    assign hold_len  = MAX_BITS'(1) << bit_pos_reg;
    assign hold_done = tick_inc >= hold_len;
    assign wrap      = hold_done && (pos_inc >= eff_bits);

    // Pins show bit k of each active level; positions past the level width read 0
    always_comb
    begin
        fcbapwm_pkg::level_t shifted;
        for (int c = 0; c < fcbapwm_pkg::NUM_CH; c++)
        begin
            shifted      = active_reg[c] >> bit_pos_reg;
            pins_next[c] = shifted[0];
        end
    end

    always_comb
    begin
        active_next        = active_reg;
        pending_next       = pending_reg;
        pending_valid_next = pending_valid_reg;
        bit_pos_next       = bit_pos_reg;
        tick_next          = tick_reg;
        frame_start_next   = 1'b0;

        if (item.opcode == fcbapwm_pkg::OP_LOAD)
        begin
            pending_next[fcbapwm_pkg::CH_RED]   = item.red_level;
            pending_next[fcbapwm_pkg::CH_GREEN] = item.green_level;
            pending_next[fcbapwm_pkg::CH_BLUE]  = item.blue_level;
            pending_next[fcbapwm_pkg::CH_WHITE] = item.white_level;
            pending_valid_next                  = 1'b1;
        end
        else
        begin
            frame_start_next = (bit_pos_reg == '0) && (tick_reg == '0);
            if (!hold_done)
            begin
                tick_next = tick_inc[TW-1:0];
            end
            else
            begin
                tick_next = '0;
                if (wrap)
                begin
                    bit_pos_next = '0;
                    // Swap in the pending set only at the frame boundary
                    if (pending_valid_reg)
                    begin
                        active_next        = pending_reg;
                        pending_valid_next = 1'b0;
                    end
                end
                else
                begin
                    bit_pos_next = pos_inc[BPW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= '0;
            pending_reg       <= '0;
            pending_valid_reg <= 1'b0;
            bit_pos_reg       <= '0;
            tick_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                active_reg        <= active_next;
                pending_reg       <= pending_next;
                pending_valid_reg <= pending_valid_next;
                bit_pos_reg       <= bit_pos_next;
                tick_reg          <= tick_next;
                out_valid_reg     <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pins_reg        <= pins_next;
            frame_start_reg <= frame_start_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.red_pin     = pins_reg[fcbapwm_pkg::CH_RED];
    assign result.green_pin   = pins_reg[fcbapwm_pkg::CH_GREEN];
    assign result.blue_pin    = pins_reg[fcbapwm_pkg::CH_BLUE];
    assign result.white_pin   = pins_reg[fcbapwm_pkg::CH_WHITE];
    assign result.frame_start = frame_start_reg;

    // Checks
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        MAX_BITS'(bit_pos_reg) < MAX_BITS'(MAX_BITS))
        else $error("bit position beyond MAX_BITS");

    a_tick_below_hold: assert property (@(posedge clk) disable iff (!rst_n)
        MAX_BITS'(tick_reg) < hold_len)
        else $error("tick count beyond hold length of current bit");

    a_load_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.opcode == fcbapwm_pkg::OP_LOAD) |=> pending_valid_reg)
        else $error("load transfer did not set pending flag");

    a_frame_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.opcode == fcbapwm_pkg::OP_TICK && bit_pos_reg == '0 &&
         tick_reg == '0) |=> (result.valid && result.frame_start))
        else $error("first tick of frame not flagged");

    a_load_holds_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.opcode == fcbapwm_pkg::OP_LOAD) |=>
        ($stable(bit_pos_reg) && $stable(tick_reg) && !result.frame_start))
        else $error("load transfer moved the bit timing");

endmodule
